// ===== rtl/clsr_pkg.sv =====
// ----------------------------------------------------------------------------
// clsr_pkg - shared types and constants of the combined LCG shuffle generator
// Item formats of both channels, generator moduli and multipliers, fold
// constants for the modular reduction and the fraction clamp.
// ----------------------------------------------------------------------------
package clsr_pkg;

    localparam int unsigned W = 31;

    typedef struct packed {
        logic         mode;
        logic [W-1:0] seed_value;
    } t_in_item;

    typedef struct packed {
        logic [W-1:0] draw;
        logic [W-1:0] fraction;
    } t_out_item;

    // request to the modular multiplier
    typedef struct packed {
        logic         sel_b;
        logic [W-1:0] op;
    } t_mm_req;

    // table write port
    typedef struct packed {
        logic         en;
        logic [W-1:0] data;
    } t_tbl_wr;

    localparam logic [W-1:0] MOD_A    = 31'd2147483563;
    localparam logic [W-1:0] MOD_B    = 31'd2147483399;
    localparam logic [15:0]  MUL_A    = 16'd40014;
    localparam logic [15:0]  MUL_B    = 16'd40692;
    // 2^31 mod MOD_A and 2^31 mod MOD_B
    localparam logic [7:0]   FOLD_A   = 8'd85;
    localparam logic [7:0]   FOLD_B   = 8'd249;
    localparam logic [W-1:0] X_RESET  = 31'd1;
    localparam logic [W-1:0] Y_RESET  = 31'd123456789;
    localparam logic [W-1:0] FRAC_MAX = 31'd2147483390;

endpackage

// ===== rtl/clsr_mulmod.sv =====
// ----------------------------------------------------------------------------
// clsr_mulmod - shared two-stage modular multiplier
// Computes 40014*v mod MOD_A or 40692*v mod MOD_B. Stage one forms the 47-bit
// product, stage two folds the bits above 2^31 back and corrects once.
// ----------------------------------------------------------------------------
module clsr_mulmod (
    input  logic                i_clk,
    input  clsr_pkg::t_mm_req   i_req,
    output logic [30:0]         o_res
);

    logic [46:0] r_prod;
    logic        r_sel_b;
    logic [30:0] r_res;

    logic [15:0] mul;
    logic [7:0]  fold;
    logic [30:0] modulus;
    logic [23:0] fold_prod;
    logic [31:0] sum;
    logic [31:0] red;

    assign mul = i_req.sel_b ? clsr_pkg::MUL_B : clsr_pkg::MUL_A;

    always_ff @(posedge i_clk) begin
        r_prod  <= 47'(i_req.op) * 47'(mul);
        r_sel_b <= i_req.sel_b;
    end

    always_comb begin
        fold      = r_sel_b ? clsr_pkg::FOLD_B : clsr_pkg::FOLD_A;
        modulus   = r_sel_b ? clsr_pkg::MOD_B : clsr_pkg::MOD_A;
        fold_prod = 24'(r_prod[46:31]) * 24'(fold);
        sum       = 32'(r_prod[30:0]) + 32'(fold_prod);
        // sum stays below twice the modulus
        red       = (sum >= 32'(modulus)) ? (sum - 32'(modulus)) : sum;
    end

    always_ff @(posedge i_clk) begin
        r_res <= red[30:0];
    end

    assign o_res = r_res;

endmodule

// ===== rtl/clsr_table.sv =====
// ----------------------------------------------------------------------------
// clsr_table - Bays-Durham shuffle table
// One write and one registered read a cycle. Per-entry valid bits cleared at
// reset make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module clsr_table #(
    parameter int DEPTH = 32,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clsr_pkg::t_tbl_wr   i_wr,
    input  logic [IDX_W-1:0]    i_wr_idx,
    input  logic [IDX_W-1:0]    i_rd_idx,
    output logic [30:0]         o_rd_data
);

    logic [30:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [30:0]      r_rd_data;
    logic             r_rd_vld;
    logic             rd_hit;

    assign rd_hit = ({1'b0, i_rd_idx} < (IDX_W+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_idx] <= i_wr.data;
        end
        if (rd_hit) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            r_rd_vld <= rd_hit ? r_valid[i_rd_idx] : 1'b0;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 31'd0;

endmodule

// ===== rtl/combined_lcg_shuffle_rng.sv =====
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng - combined LCG generator behind a shuffle table
// Items are taken one at a time: o_in_stall stays high until the draw of the
// last item has entered the output register, which waits while the output is
// stalled. A reseed first steps the first generator TABLE_DEPTH+8 times through
// the shared two-stage modular multiplier, which also serves every draw.
// Reset: synchronous, loads the generators with their reset values, clears the
// shuffle output, the output valid and the table valid bits.
module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  clsr_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output clsr_pkg::t_out_item   o_out_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int QW    = $clog2(TABLE_DEPTH) + 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 8);
    // slot = draw / SPAN_L by reciprocal multiplication, exact for 31-bit draws
    localparam longint SPAN_L = 64'sd1 + (64'sd2147483562 / longint'(TABLE_DEPTH));
    localparam int     RSH    = 31 + $clog2(SPAN_L);
    localparam logic [31:0] RECIP =
        32'(((64'sd1 <<< RSH) + SPAN_L - 64'sd1) / SPAN_L);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SEED_MUL = 4'd1;
    localparam logic [3:0] S_SEED_RED = 4'd2;
    localparam logic [3:0] S_SEED_WB  = 4'd3;
    localparam logic [3:0] S_DIV      = 4'd4;
    localparam logic [3:0] S_MUL_X    = 4'd5;
    localparam logic [3:0] S_MUL_Y    = 4'd6;
    localparam logic [3:0] S_GET_X    = 4'd7;
    localparam logic [3:0] S_GET_Y    = 4'd8;
    localparam logic [3:0] S_FRAC     = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [30:0]   r_x, n_x;
    logic [30:0]   r_y, n_y;
    logic [30:0]   r_so, n_so;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [QW-1:0] r_q, n_q;
    logic [30:0]   r_frac, n_frac;
    logic          r_ovalid, n_ovalid;
    clsr_pkg::t_out_item r_out, n_out;

    clsr_pkg::t_mm_req mm_req;
    logic [30:0]       mm_res;
    clsr_pkg::t_tbl_wr tbl_wr;
    logic [IDX_W-1:0]  tbl_wr_idx;
    logic [30:0]       tbl_rd;

    logic          in_xfer;
    logic [30:0]   seed;
    logic [62:0]   slot_prod;
    logic          slot_ok;
    logic [30:0]   picked;
    logic [32:0]   mix;
    logic [37:0]   t85;
    logic [31:0]   fold_sum;
    logic [31:0]   frac_q;

    clsr_mulmod u_mulmod (
        .i_clk (i_clk),
        .i_req (mm_req),
        .o_res (mm_res)
    );

    clsr_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_wr_idx  (tbl_wr_idx),
        .i_rd_idx  (r_q[IDX_W-1:0]),
        .o_rd_data (tbl_rd)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_comb begin
        // reduce the seed once, then map zero to one
        seed = (i_in_data.seed_value >= clsr_pkg::MOD_A) ?
               (i_in_data.seed_value - clsr_pkg::MOD_A) : i_in_data.seed_value;
        if (seed == 31'd0) begin
            seed = 31'd1;
        end

        slot_prod = 63'(r_so) * 63'(RECIP);
        slot_ok   = (r_q < QW'(TABLE_DEPTH));
        picked    = slot_ok ? tbl_rd : 31'd0;
        mix       = {2'b00, picked} - {2'b00, mm_res};
        if (mix[32] || (mix == 33'd0)) begin
            mix = mix + 33'(clsr_pkg::MOD_A - 31'd1);
        end

        // floor(d*2^31/MOD_A) = d + floor(85*d/MOD_A)
        t85      = 38'(r_so) + (38'(r_so) << 2) + (38'(r_so) << 4) + (38'(r_so) << 6);
        fold_sum = 32'(t85[30:0]) + (32'(t85[37:31]) * 32'(clsr_pkg::FOLD_A));
        frac_q   = 32'(r_so) + 32'(t85[37:31])
                 + 32'(fold_sum >= 32'(clsr_pkg::MOD_A));
    end

    always_comb begin
        n_state    = r_state;
        n_x        = r_x;
        n_y        = r_y;
        n_so       = r_so;
        n_cnt      = r_cnt;
        n_q        = r_q;
        n_frac     = r_frac;
        n_ovalid   = r_ovalid;
        n_out      = r_out;
        mm_req     = '{sel_b: 1'b0, op: r_x};
        tbl_wr     = '{en: 1'b0, data: mm_res};
        tbl_wr_idx = r_cnt[IDX_W-1:0];

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.mode) begin
                        n_x     = seed;
                        n_y     = seed;
                        n_cnt   = CW'(TABLE_DEPTH + 7);
                        n_state = S_SEED_MUL;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_SEED_MUL: begin
                n_state = S_SEED_RED;
            end
            S_SEED_RED: begin
                n_state = S_SEED_WB;
            end
            S_SEED_WB: begin
                n_x = mm_res;
                if (r_cnt < CW'(TABLE_DEPTH)) begin
                    tbl_wr.en = 1'b1;
                end
                if (r_cnt == '0) begin
                    // entry zero seeds the shuffle output
                    n_so    = mm_res;
                    n_state = S_DIV;
                end else begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = S_SEED_MUL;
                end
            end
            S_DIV: begin
                n_q     = QW'(slot_prod >> RSH);
                n_state = S_MUL_X;
            end
            S_MUL_X: begin
                n_state = S_MUL_Y;
            end
            S_MUL_Y: begin
                mm_req  = '{sel_b: 1'b1, op: r_y};
                n_state = S_GET_X;
            end
            S_GET_X: begin
                n_x     = mm_res;
                n_state = S_GET_Y;
            end
            S_GET_Y: begin
                n_y        = mm_res;
                tbl_wr     = '{en: slot_ok, data: r_x};
                tbl_wr_idx = r_q[IDX_W-1:0];
                n_so       = mix[30:0];
                n_state    = S_FRAC;
            end
            S_FRAC: begin
                n_frac  = (frac_q > 32'(clsr_pkg::FRAC_MAX)) ?
                          clsr_pkg::FRAC_MAX : frac_q[30:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || !i_out_stall) begin
                    n_out    = '{draw: r_so, fraction: r_frac};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_x      <= clsr_pkg::X_RESET;
            r_y      <= clsr_pkg::Y_RESET;
            r_so     <= 31'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_x      <= n_x;
            r_y      <= n_y;
            r_so     <= n_so;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_q    <= n_q;
        r_frac <= n_frac;
        r_out  <= n_out;
    end

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_X) |-> (r_q < QW'(TABLE_DEPTH)))
        else $error("shuffle slot beyond table depth");

    a_draw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAC) |-> ((r_so != 31'd0) && (r_so < clsr_pkg::MOD_A)))
        else $error("draw outside 1..MOD_A-1");

    a_gen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_x < clsr_pkg::MOD_A))
        else $error("first generator not reduced");

    a_frac_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_out_data.fraction <= clsr_pkg::FRAC_MAX))
        else $error("fraction above clamp");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - testbench of the combined LCG shuffle generator
// Draws after reset on the cleared table, reseeds at the seed extremes, and
// random traffic with and without random idling on both channels. Every result is
// compared with a cycle-free model of both generators and the shuffle table.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     W          = clsr_pkg::W;
    localparam int     DEPTH      = 32;
    localparam longint MOD_X      = longint'(clsr_pkg::MOD_A);
    localparam longint MOD_Y      = longint'(clsr_pkg::MOD_B);
    localparam longint QUO_X      = 53668;
    localparam longint QUO_Y      = 52774;
    localparam longint REM_X      = 12211;
    localparam longint REM_Y      = 3791;
    localparam longint SLOT_SPAN  = 1 + (MOD_X - 1) / DEPTH;
    localparam int     WATCHDOG   = 3000;
    localparam int     DRAIN      = 200;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    clsr_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    clsr_pkg::t_out_item o_out_data;

    // generator model
    longint      gen_x = longint'(clsr_pkg::X_RESET);
    longint      gen_y = longint'(clsr_pkg::Y_RESET);
    longint      last_draw = 0;
    longint      mix_table [DEPTH] = '{default: 0};

    clsr_pkg::t_out_item expected_draws [$];
    int          fail_count = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;

    combined_lcg_shuffle_rng #(.TABLE_DEPTH(DEPTH)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint lcg_step(longint v, longint mul, longint quo, longint rem,
                                        longint modulus);
        longint k;
        longint r;
        k = v / quo;
        r = mul * (v - k * quo) - k * rem;
        if (r < 0) r += modulus;
        return r;
    endfunction

    function automatic clsr_pkg::t_out_item next_draw(clsr_pkg::t_in_item item);
        longint              seed;
        longint              slot;
        longint              picked;
        longint unsigned     scaled;
        clsr_pkg::t_out_item res;
        int                  i;
        if (item.mode) begin
            seed = longint'(item.seed_value);
            if (seed >= MOD_X) seed -= MOD_X;
            if (seed == 0) seed = 1;
            gen_x = seed;
            gen_y = seed;
            // warm up, filling the table from the top entry down
            for (i = DEPTH + 7; i >= 0; i--) begin
                gen_x = lcg_step(gen_x, longint'(clsr_pkg::MUL_A), QUO_X, REM_X, MOD_X);
                if (i < DEPTH) mix_table[i] = gen_x;
            end
            last_draw = mix_table[0];
        end
        gen_x = lcg_step(gen_x, longint'(clsr_pkg::MUL_A), QUO_X, REM_X, MOD_X);
        gen_y = lcg_step(gen_y, longint'(clsr_pkg::MUL_B), QUO_Y, REM_Y, MOD_Y);
        slot   = last_draw / SLOT_SPAN;
        picked = 0;
        if (slot >= 0 && slot < DEPTH) begin
            picked = mix_table[slot];
            mix_table[slot] = gen_x;
        end
        last_draw = picked - gen_y;
        if (last_draw < 1) last_draw += MOD_X - 1;
        scaled = (longint'(last_draw) << 31) / MOD_X;
        if (scaled > longint'(clsr_pkg::FRAC_MAX)) scaled = longint'(clsr_pkg::FRAC_MAX);
        res.draw     = last_draw[W-1:0];
        res.fraction = scaled[W-1:0];
        return res;
    endfunction

    // Hold the item until it transfers, then record its expected draw.
    task automatic send_item(input clsr_pkg::t_in_item item);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 25) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_draws.push_back(next_draw(item));
    endtask

    function automatic clsr_pkg::t_in_item random_item();
        clsr_pkg::t_in_item item;
        int                 pick;
        item.mode       = ($urandom_range(0, 99) < 8);
        item.seed_value = W'($urandom);
        pick = $urandom_range(0, 9);
        if (item.mode && pick < 7)
            item.seed_value = W'($urandom_range(0, clsr_pkg::MOD_A - 1));
        else if (item.mode && pick == 7)
            item.seed_value = '0;
        return item;
    endfunction

    task automatic test_unseeded_draws();
        repeat (3) send_item('{mode: 1'b0, seed_value: W'($urandom)});
    endtask

    task automatic test_seed_edges();
        logic [W-1:0] seeds [8];
        seeds = '{'0, W'(1), clsr_pkg::MOD_A - 1, clsr_pkg::MOD_A,
                  clsr_pkg::MOD_A + 5, '1, W'('h2AAAAAAA), W'('h55555555)};
        foreach (seeds[n]) begin
            send_item('{mode: 1'b1, seed_value: seeds[n]});
            send_item('{mode: 1'b0, seed_value: ~seeds[n]});
        end
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_item(random_item());
    endtask

    task automatic test_back_to_back(input int count);
        calm = 1'b1;
        repeat (count) send_item(random_item());
        calm = 1'b0;
    endtask

    task automatic finish_run();
        i_in_valid <= 1'b0;
        while (expected_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0)
            $display("** combined_lcg_shuffle_rng: PASSED **");
        else
            $display("** combined_lcg_shuffle_rng: FAILED **");
        $finish;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 25);
    end

    // Compare each output transfer with the oldest expectation.
    always @(posedge i_clk) begin
        clsr_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_draws.size() == 0) begin
                $error("unexpected result: draw %0d, fraction %0d",
                       o_out_data.draw, o_out_data.fraction);
                fail_count++;
            end else begin
                want = expected_draws.pop_front();
                if (o_out_data.draw !== want.draw) begin
                    $error("draw mismatch: expected %0d, got %0d", want.draw, o_out_data.draw);
                    fail_count++;
                end
                if (o_out_data.fraction !== want.fraction) begin
                    $error("fraction mismatch: expected %0d, got %0d",
                           want.fraction, o_out_data.fraction);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("** combined_lcg_shuffle_rng: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unseeded_draws();
        test_seed_edges();
        test_random_traffic(550);
        test_back_to_back(200);
        test_random_traffic(530);
        finish_run();
    end

endmodule

// ===== sim.f =====
rtl/clsr_pkg.sv
rtl/clsr_mulmod.sv
rtl/clsr_table.sv
rtl/combined_lcg_shuffle_rng.sv
tb/tb_top.sv
